### hdl/ddals_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ddals_pkg;

	localparam int COORD_BITS = 10;
	localparam int FRAC_BITS  = 16;
	localparam int DASH_W     = 4;

	// long division keeps one integer bit since |d| never exceeds the step count
	localparam int DIV_ITERS = FRAC_BITS + 1;
	localparam int CNT_W     = $clog2(DIV_ITERS);
	localparam int REM_W     = COORD_BITS + 1;
	localparam int QUO_W     = FRAC_BITS + 1;
	localparam int INC_W     = FRAC_BITS + 2;
	localparam int POS_W     = COORD_BITS + FRAC_BITS + 1;
	localparam int IDX_W     = COORD_BITS + 1;
	localparam int ADV_W     = DASH_W + 1;

	localparam int IN_TDATA_W  = ((4 * COORD_BITS + 7) / 8) * 8;
	localparam int OUT_TDATA_W = ((2 * COORD_BITS + 7) / 8) * 8;

	localparam logic OP_START = 1'b0;
	localparam logic OP_STEP  = 1'b1;

	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_DASH_ON  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_DASH_OFF = 1'b1;

	localparam logic [DASH_W-1:0] DASH_ON_RST  = 4'd10;
	localparam logic [DASH_W-1:0] DASH_OFF_RST = 4'd5;

	typedef struct packed {
		logic load;
		logic step;
		logic div_step;
		logic div_last;
	} ctrl_cmd_t;

	typedef struct packed {
		logic out_free;
	} dp_status_t;

endpackage
`default_nettype wire

### hdl/ddals_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module ddals_ctrl (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   s_tvalid,
	output logic                  s_tready,
	input  wire                   s_tuser,
	input  ddals_pkg::dp_status_t status,
	output ddals_pkg::ctrl_cmd_t  cmd
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_DIV  = 1'b1;

	logic                       state_q;
	logic [ddals_pkg::CNT_W-1:0] cnt_q;
	logic                       accept;
	logic                       cnt_last;

	assign s_tready = (state_q == ST_IDLE) && status.out_free;
	assign accept   = s_tvalid && s_tready;
	assign cnt_last = (cnt_q == ddals_pkg::CNT_W'(ddals_pkg::DIV_ITERS - 1));

	always_comb begin
		cmd          = '0;
		cmd.load     = accept && (s_tuser == ddals_pkg::OP_START);
		cmd.step     = accept && (s_tuser == ddals_pkg::OP_STEP);
		cmd.div_step = (state_q == ST_DIV);
		cmd.div_last = (state_q == ST_DIV) && cnt_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.load) begin
						state_q <= ST_DIV;
						cnt_q   <= '0;
					end
				end
				ST_DIV: begin
					if (cnt_last) begin
						state_q <= ST_IDLE;
					end
					cnt_q <= cnt_q + 1'b1;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_load_enters_div: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (state_q == ST_DIV) && (cnt_q == '0))
		else $error("start beat did not launch the division");

	a_div_ends: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_last |=> (state_q == ST_IDLE))
		else $error("division overran its iteration count");

	a_no_beat_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> !cmd.load && !cmd.step)
		else $error("beat taken while dividing");

endmodule
`default_nettype wire

### hdl/ddals_dp.sv
`timescale 1ns / 1ps
`default_nettype none
module ddals_dp (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire [ddals_pkg::IN_TDATA_W-1:0]       s_tdata,
	input  wire                                   cfg_we,
	input  wire [ddals_pkg::CFG_IDX_W-1:0]        cfg_addr,
	input  wire [ddals_pkg::DASH_W-1:0]           cfg_data,
	input  ddals_pkg::ctrl_cmd_t                  cmd,
	output ddals_pkg::dp_status_t                 status,
	output logic                                  m_tvalid,
	input  wire                                   m_tready,
	output logic [ddals_pkg::OUT_TDATA_W-1:0]     m_tdata,
	output logic                                  m_tlast
);

	localparam int CB = ddals_pkg::COORD_BITS;
	localparam int FB = ddals_pkg::FRAC_BITS;

	logic [ddals_pkg::DASH_W-1:0] dash_on_q, dash_off_q, dash_count_q;
	logic                         line_active_q;

	logic signed [ddals_pkg::POS_W-1:0] pos_x_q, pos_y_q;
	logic signed [ddals_pkg::INC_W-1:0] inc_x_q, inc_y_q;
	logic [ddals_pkg::IDX_W-1:0]        step_index_q, step_total_q;

	logic [ddals_pkg::REM_W-1:0] rem_x_q, rem_y_q;
	logic [ddals_pkg::QUO_W-1:0] quo_x_q, quo_y_q;
	logic                        neg_x_q, neg_y_q;

	logic [CB-1:0] px_q, py_q;
	logic          valid_q, last_q;

	// start decode
	logic [CB-1:0]   xs, ys, xe, ye, ax, ay;
	logic signed [CB:0] dx, dy;
	logic [CB-1:0]   steps;

	assign xs = s_tdata[0*CB +: CB];
	assign ys = s_tdata[1*CB +: CB];
	assign xe = s_tdata[2*CB +: CB];
	assign ye = s_tdata[3*CB +: CB];
	assign dx = $signed({1'b0, xe}) - $signed({1'b0, xs});
	assign dy = $signed({1'b0, ye}) - $signed({1'b0, ys});
	assign ax = dx[CB] ? CB'(-dx) : dx[CB-1:0];
	assign ay = dy[CB] ? CB'(-dy) : dy[CB-1:0];
	assign steps = (ax > ay) ? ax : ay;

	// one quotient bit per cycle for both axes
	logic                        cmp_x, cmp_y;
	logic [ddals_pkg::REM_W-1:0] rn_x, rn_y;
	logic [ddals_pkg::QUO_W-1:0] qf_x, qf_y;
	logic [ddals_pkg::INC_W-1:0] qe_x, qe_y;
	logic                        zero_len;

	assign cmp_x = rem_x_q >= step_total_q;
	assign cmp_y = rem_y_q >= step_total_q;
	assign rn_x  = cmp_x ? rem_x_q - step_total_q : rem_x_q;
	assign rn_y  = cmp_y ? rem_y_q - step_total_q : rem_y_q;
	assign qf_x  = {quo_x_q[ddals_pkg::QUO_W-2:0], cmp_x};
	assign qf_y  = {quo_y_q[ddals_pkg::QUO_W-2:0], cmp_y};
	assign qe_x  = {1'b0, qf_x};
	assign qe_y  = {1'b0, qf_y};
	assign zero_len = (step_total_q == '0);

	// stepping
	logic [ddals_pkg::DASH_W-1:0] on_eff, dc_inc;
	logic                         dash_end, fin;
	logic [ddals_pkg::ADV_W-1:0]  adv;
	logic signed [ddals_pkg::INC_W+ddals_pkg::ADV_W:0] prod_x, prod_y;

	assign on_eff   = (dash_on_q == '0) ? ddals_pkg::DASH_W'(1) : dash_on_q;
	assign dc_inc   = dash_count_q + 1'b1;
	assign dash_end = (dc_inc == on_eff) || (on_eff == ddals_pkg::DASH_W'(1));
	assign adv      = dash_end ? ({1'b0, dash_off_q} + 1'b1) : ddals_pkg::ADV_W'(1);
	assign fin      = ({1'b0, step_index_q} + (ddals_pkg::IDX_W + 1)'(adv))
	                  > {1'b0, step_total_q};
	assign prod_x   = inc_x_q * $signed({1'b0, adv});
	assign prod_y   = inc_y_q * $signed({1'b0, adv});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dash_on_q     <= ddals_pkg::DASH_ON_RST;
			dash_off_q    <= ddals_pkg::DASH_OFF_RST;
			line_active_q <= 1'b0;
			valid_q       <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_addr)
					ddals_pkg::REG_DASH_ON:  dash_on_q  <= cfg_data;
					ddals_pkg::REG_DASH_OFF: dash_off_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.load) begin
				line_active_q <= 1'b1;
			end else if (cmd.step && line_active_q && fin) begin
				line_active_q <= 1'b0;
			end
			if (cmd.step && line_active_q) begin
				valid_q <= 1'b1;
			end else if (m_tready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			step_total_q <= ddals_pkg::IDX_W'(steps);
			step_index_q <= '0;
			dash_count_q <= '0;
			rem_x_q      <= ddals_pkg::REM_W'(ax);
			rem_y_q      <= ddals_pkg::REM_W'(ay);
			quo_x_q      <= '0;
			quo_y_q      <= '0;
			neg_x_q      <= dx[CB];
			neg_y_q      <= dy[CB];
			pos_x_q      <= $signed({1'b0, xs, {FB{1'b0}}});
			pos_y_q      <= $signed({1'b0, ys, {FB{1'b0}}});
		end
		if (cmd.div_step) begin
			rem_x_q <= {rn_x[ddals_pkg::REM_W-2:0], 1'b0};
			rem_y_q <= {rn_y[ddals_pkg::REM_W-2:0], 1'b0};
			quo_x_q <= qf_x;
			quo_y_q <= qf_y;
		end
		if (cmd.div_last) begin
			inc_x_q <= zero_len ? '0 : (neg_x_q ? $signed(-qe_x) : $signed(qe_x));
			inc_y_q <= zero_len ? '0 : (neg_y_q ? $signed(-qe_y) : $signed(qe_y));
		end
		if (cmd.step && line_active_q) begin
			px_q   <= pos_x_q[FB +: CB];
			py_q   <= pos_y_q[FB +: CB];
			last_q <= fin;
			dash_count_q <= dash_end ? '0 : dc_inc;
			if (!fin) begin
				step_index_q <= step_index_q + ddals_pkg::IDX_W'(adv);
				pos_x_q      <= pos_x_q + ddals_pkg::POS_W'(prod_x);
				pos_y_q      <= pos_y_q + ddals_pkg::POS_W'(prod_y);
			end
		end
	end

	assign status.out_free = !valid_q || m_tready;
	assign m_tvalid = valid_q;
	assign m_tlast  = last_q;
	assign m_tdata  = ddals_pkg::OUT_TDATA_W'({py_q, px_q});

	a_end_gives_last: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(line_active_q) |-> m_tvalid && m_tlast)
		else $error("line closed without a last pixel");

	a_index_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		line_active_q && !$past(cmd.load) |-> step_index_q <= step_total_q)
		else $error("step index ran past the step count");

endmodule
`default_nettype wire

### hdl/dashed_dda_line_stepper.sv
// Dashed DDA line stepper.
// Input stream s_*: tuser carries the op bit (0 = start a line, 1 = next pixel);
// tdata carries x_start, y_start, x_end, y_end for a start beat.
// Output stream m_*: tdata = pixel_x, pixel_y; tlast marks the line's final pixel.
// cfg_we/cfg_addr/cfg_data write dash_on (index 0) and dash_off (index 1),
// taken at any edge with cfg_we high; write them only while the block is idle.
// A start beat gives no pixel and holds s_tready low while a
// one-bit-per-cycle long division (FRAC_BITS + 1 steps) forms the increments.
// Step beats then run one per cycle while the output is not stalled:
// each pixel appears on m_* the cycle after its beat is taken. A step beat
// with no line active is swallowed. s_tready also drops while a pixel sits in
// the output register and m_tready is low; nothing is lost or repeated.
// Reset clears the line, empties the output register and restores
// dash_on = 10, dash_off = 5.
`timescale 1ns / 1ps
`default_nettype none
module dashed_dda_line_stepper (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                s_tvalid,
	output logic                               s_tready,
	input  wire [ddals_pkg::IN_TDATA_W-1:0]    s_tdata,  // x_start, y_start, x_end, y_end
	input  wire                                s_tuser,  // op
	output logic                               m_tvalid,
	input  wire                                m_tready,
	output logic [ddals_pkg::OUT_TDATA_W-1:0]  m_tdata,  // pixel_x, pixel_y, zero pad
	output logic                               m_tlast,
	input  wire                                cfg_we,
	input  wire [ddals_pkg::CFG_IDX_W-1:0]     cfg_addr,
	input  wire [ddals_pkg::DASH_W-1:0]        cfg_data
);

	ddals_pkg::ctrl_cmd_t  cmd;
	ddals_pkg::dp_status_t status;

	ddals_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.status   (status),
		.cmd      (cmd)
	);

	ddals_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_data (cfg_data),
		.cmd      (cmd),
		.status   (status),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule
`default_nettype wire

### tb/sv/tb_dashed_dda_line_stepper.sv
`timescale 1ns / 1ps
module tb_dashed_dda_line_stepper;

	localparam int LIMIT_CYCLES = 200000;
	localparam int DRAIN_CYCLES = 24;
	localparam int N_PHASES     = 8;
	localparam int PHASE_BEATS  = 150;

	typedef logic signed [ddals_pkg::POS_W:0] fix_t;

	typedef struct packed {
		logic                             op;
		logic [ddals_pkg::COORD_BITS-1:0] xs;
		logic [ddals_pkg::COORD_BITS-1:0] ys;
		logic [ddals_pkg::COORD_BITS-1:0] xe;
		logic [ddals_pkg::COORD_BITS-1:0] ye;
	} line_beat_t;

	typedef struct packed {
		logic [ddals_pkg::COORD_BITS-1:0] x;
		logic [ddals_pkg::COORD_BITS-1:0] y;
		logic                             last;
	} pixel_t;

	logic                              clk      = 1'b0;
	logic                              arst_n   = 1'b0;
	logic                              s_tvalid = 1'b0;
	wire                               s_tready;
	logic [ddals_pkg::IN_TDATA_W-1:0]  s_tdata  = '0;  // x_start, y_start, x_end, y_end
	logic                              s_tuser  = 1'b0; // op
	wire                               m_tvalid;
	logic                              m_tready = 1'b0;
	wire [ddals_pkg::OUT_TDATA_W-1:0]  m_tdata;         // pixel_x, pixel_y, zero pad
	wire                               m_tlast;
	logic                              cfg_we   = 1'b0;
	logic [ddals_pkg::CFG_IDX_W-1:0]   cfg_addr = '0;
	logic [ddals_pkg::DASH_W-1:0]      cfg_data = '0;

	dashed_dda_line_stepper uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_data (cfg_data)
	);

	// line tracker state
	logic [ddals_pkg::DASH_W-1:0] dash_on_cfg  = ddals_pkg::DASH_ON_RST;
	logic [ddals_pkg::DASH_W-1:0] dash_off_cfg = ddals_pkg::DASH_OFF_RST;
	fix_t                         pos_x = '0, pos_y = '0, inc_x = '0, inc_y = '0;
	logic [ddals_pkg::IDX_W-1:0]  idx_now = '0, idx_total = '0;
	logic [ddals_pkg::DASH_W-1:0] dash_drawn = '0;
	logic                         line_on = 1'b0;

	line_beat_t beat_q[$];
	pixel_t     expected_pixels[$];
	line_beat_t on_bus;
	pixel_t     want;

	int queued_beats   = 0;
	int accepted_beats = 0;
	int src_idle_pct   = 0;
	int snk_stall_pct  = 0;
	int mismatches     = 0;
	int cycles         = 0;

	// -1 picks a random setting
	int dash_on_plan[N_PHASES]  = '{1, 15, 0, 3, -1, 15, 1, -1};
	int dash_off_plan[N_PHASES] = '{0, 15, 7, 2, -1, 0, 15, -1};

	function automatic logic [ddals_pkg::IDX_W-1:0] absdiff(
			input logic [ddals_pkg::COORD_BITS-1:0] a, z);
		return (z >= a) ? ddals_pkg::IDX_W'(z - a) : ddals_pkg::IDX_W'(a - z);
	endfunction

	// |d| << FRAC_BITS / n, truncated, then signed (rounds toward zero)
	function automatic fix_t line_inc(input logic [ddals_pkg::COORD_BITS-1:0] a, z,
			input logic [ddals_pkg::IDX_W-1:0] n);
		logic [ddals_pkg::IDX_W+ddals_pkg::FRAC_BITS-1:0] q;
		if (n == '0)
			return '0;
		q = {absdiff(a, z), {ddals_pkg::FRAC_BITS{1'b0}}} / n;
		return (z >= a) ? fix_t'(q) : -fix_t'(q);
	endfunction

	function automatic void trace_beat(input line_beat_t b);
		logic [ddals_pkg::IDX_W-1:0]  ax, ay;
		logic [ddals_pkg::DASH_W-1:0] on;
		logic [ddals_pkg::ADV_W-1:0]  adv;
		pixel_t                       px;
		if (b.op == ddals_pkg::OP_START) begin
			ax = absdiff(b.xs, b.xe);
			ay = absdiff(b.ys, b.ye);
			idx_total = (ax > ay) ? ax : ay;
			inc_x = line_inc(b.xs, b.xe, idx_total);
			inc_y = line_inc(b.ys, b.ye, idx_total);
			pos_x = fix_t'(b.xs) <<< ddals_pkg::FRAC_BITS;
			pos_y = fix_t'(b.ys) <<< ddals_pkg::FRAC_BITS;
			idx_now = '0;
			dash_drawn = '0;
			line_on = 1'b1;
		end else if (line_on) begin
			px.x = pos_x[ddals_pkg::FRAC_BITS +: ddals_pkg::COORD_BITS];
			px.y = pos_y[ddals_pkg::FRAC_BITS +: ddals_pkg::COORD_BITS];
			on = (dash_on_cfg == '0) ? ddals_pkg::DASH_W'(1) : dash_on_cfg;
			adv = ddals_pkg::ADV_W'(1);
			dash_drawn = dash_drawn + 1'b1;
			if (dash_drawn == on || on == ddals_pkg::DASH_W'(1)) begin
				// dash complete: jump over the gap
				dash_drawn = '0;
				adv = ddals_pkg::ADV_W'(1) + ddals_pkg::ADV_W'(dash_off_cfg);
			end
			px.last = (32'(idx_now) + 32'(adv)) > 32'(idx_total);
			if (px.last) begin
				line_on = 1'b0;
			end else begin
				idx_now = idx_now + ddals_pkg::IDX_W'(adv);
				pos_x = pos_x + inc_x * fix_t'(adv);
				pos_y = pos_y + inc_y * fix_t'(adv);
			end
			expected_pixels.push_back(px);
		end
	endfunction

	task automatic report_mismatch(input string what);
		mismatches++;
		if (mismatches <= 100)
			$display("%0t mismatch: %s", $time, what);
	endtask

	task automatic push_start(input int xs, ys, xe, ye);
		line_beat_t b;
		b.op = ddals_pkg::OP_START;
		b.xs = xs[ddals_pkg::COORD_BITS-1:0];
		b.ys = ys[ddals_pkg::COORD_BITS-1:0];
		b.xe = xe[ddals_pkg::COORD_BITS-1:0];
		b.ye = ye[ddals_pkg::COORD_BITS-1:0];
		beat_q.push_back(b);
		queued_beats++;
	endtask

	// step beats carry random junk in the coordinate fields
	task automatic push_steps(input int n);
		line_beat_t b;
		repeat (n) begin
			b.op = ddals_pkg::OP_STEP;
			b.xs = ddals_pkg::COORD_BITS'($urandom);
			b.ys = ddals_pkg::COORD_BITS'($urandom);
			b.xe = ddals_pkg::COORD_BITS'($urandom);
			b.ye = ddals_pkg::COORD_BITS'($urandom);
			beat_q.push_back(b);
			queued_beats++;
		end
	endtask

	function automatic int near_coord(input int c, span);
		int v;
		v = c + int'($urandom_range(2 * span)) - span;
		if (v < 0)
			v = 0;
		if (v > 1023)
			v = 1023;
		return v;
	endfunction

	task automatic queue_random(input int n_beats);
		int added, kind, span, len, n, xs, ys, xe, ye;
		added = 0;
		while (added < n_beats) begin
			kind = $urandom_range(99);
			xs = $urandom_range(1023);
			ys = $urandom_range(1023);
			if (kind < 80) begin
				// mostly short lines, now and then a long one
				span = ($urandom_range(9) == 0) ? 1023 : 24;
				xe = near_coord(xs, span);
				ye = near_coord(ys, span);
				len = int'(absdiff(ddals_pkg::COORD_BITS'(xs), ddals_pkg::COORD_BITS'(xe)));
				if (int'(absdiff(ddals_pkg::COORD_BITS'(ys), ddals_pkg::COORD_BITS'(ye))) > len)
					len = int'(absdiff(ddals_pkg::COORD_BITS'(ys),
						ddals_pkg::COORD_BITS'(ye)));
				n = $urandom_range((len + 2 < 80) ? len + 2 : 80, 1);
				push_start(xs, ys, xe, ye);
				push_steps(n);
				added += n + 1;
			end else if (kind < 90) begin
				n = $urandom_range(4, 0);
				push_start(xs, ys, $urandom_range(1023), $urandom_range(1023));
				push_steps(n);
				added += n + 1;
			end else begin
				n = $urandom_range(3, 1);
				push_steps(n);
				added += n;
			end
		end
	endtask

	task automatic wait_idle();
		do
			@(posedge clk);
		while (accepted_beats != queued_beats || expected_pixels.size() != 0);
		// a trailing start beat may still be dividing
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_dash(input logic [ddals_pkg::DASH_W-1:0] on, off);
		@(posedge clk);
		cfg_we   <= 1'b1;
		cfg_addr <= ddals_pkg::REG_DASH_ON;
		cfg_data <= on;
		@(posedge clk);
		cfg_addr <= ddals_pkg::REG_DASH_OFF;
		cfg_data <= off;
		@(posedge clk);
		cfg_we <= 1'b0;
		dash_on_cfg  = on;
		dash_off_cfg = off;
	endtask

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= LIMIT_CYCLES) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// input driver
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				trace_beat(on_bus);
				accepted_beats++;
			end
			if (!s_tvalid || s_tready) begin
				if (beat_q.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
					on_bus = beat_q.pop_front();
					s_tvalid <= 1'b1;
					s_tuser  <= on_bus.op;
					s_tdata  <= {on_bus.ye, on_bus.xe, on_bus.ys, on_bus.xs};
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// output monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (expected_pixels.size() == 0) begin
					report_mismatch($sformatf("pixel (%0d,%0d) with none expected",
						m_tdata[0 +: ddals_pkg::COORD_BITS],
						m_tdata[ddals_pkg::COORD_BITS +: ddals_pkg::COORD_BITS]));
				end else begin
					want = expected_pixels.pop_front();
					if (m_tdata[0 +: ddals_pkg::COORD_BITS] !== want.x)
						report_mismatch($sformatf("pixel_x %0d, want %0d",
							m_tdata[0 +: ddals_pkg::COORD_BITS], want.x));
					if (m_tdata[ddals_pkg::COORD_BITS +: ddals_pkg::COORD_BITS] !== want.y)
						report_mismatch($sformatf("pixel_y %0d, want %0d",
							m_tdata[ddals_pkg::COORD_BITS +: ddals_pkg::COORD_BITS],
							want.y));
					if (m_tlast !== want.last)
						report_mismatch($sformatf("last %b, want %b", m_tlast, want.last));
				end
			end
			m_tready <= ($urandom_range(99) >= snk_stall_pct);
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// step before any line, then zero-length line with a spare step
		push_steps(1);
		push_start(0, 0, 0, 0);
		push_steps(2);
		push_start(0, 0, 1023, 1023);
		push_steps(2);
		push_start(1023, 0, 0, 1023);
		push_steps(2);
		// vertical line cut short by the next start
		push_start(5, 7, 5, 40);
		push_steps(1);
		// first dash ends on the final pixel, one spare step after it
		push_start(0, 1023, 12, 1020);
		push_steps(11);
		wait_idle();

		for (int p = 0; p < N_PHASES; p++) begin
			set_dash((dash_on_plan[p] < 0) ? ddals_pkg::DASH_W'($urandom)
					: ddals_pkg::DASH_W'(dash_on_plan[p]),
				(dash_off_plan[p] < 0) ? ddals_pkg::DASH_W'($urandom)
					: ddals_pkg::DASH_W'(dash_off_plan[p]));
			case (p % 4)
				0: begin
					src_idle_pct  = 0;
					snk_stall_pct = 0;
				end
				1: begin
					src_idle_pct  = 67;
					snk_stall_pct = 0;
				end
				2: begin
					src_idle_pct  = 0;
					snk_stall_pct = 67;
				end
				default: begin
					src_idle_pct  = 35;
					snk_stall_pct = 35;
				end
			endcase
			queue_random(PHASE_BEATS);
			wait_idle();
		end

		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

### sim.f
hdl/ddals_pkg.sv
hdl/ddals_ctrl.sv
hdl/ddals_dp.sv
hdl/dashed_dda_line_stepper.sv
tb/sv/tb_dashed_dda_line_stepper.sv
